FILE: src/ppf_pkg.sv
// ============================================================================
// ppf_pkg
// Shared types, constants and helper functions for the packed parameter
// file parser.
// ============================================================================
package ppf_pkg;

    // Name store sizing.
    localparam int NAME_MAX_DEF = 16;
    localparam int NAME_IDX_W   = 4;

    // Header layout: six bytes, the last one at this position.
    localparam logic [4:0] HDR_LAST_POS = 5'd5;

    // Accepted header magic values.
    localparam logic [15:0] MAGIC_A = 16'h671B;
    localparam logic [15:0] MAGIC_B = 16'h671C;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_PAD      = 3'd1,
        PH_NAMEBYTE = 3'd2,
        PH_NAME     = 3'd3,
        PH_VALUE    = 3'd4,
        PH_DEFAULT  = 3'd5,
        PH_IGNORE   = 3'd6
    } phase_t;

    // Result status codes.
    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_TOO_SMALL   = 4'd1,
        ST_BAD_MAGIC   = 4'd2,
        ST_PARTIAL     = 4'd3,
        ST_END_EARLY   = 4'd4,
        ST_BAD_PREFIX  = 4'd5,
        ST_TRUNC_NAME  = 4'd6,
        ST_BAD_VALUE   = 4'd7,
        ST_TRUNC_DFLT  = 4'd8
    } status_t;

    // Parameter type codes.
    localparam logic [3:0] TYPE_INT8  = 4'd1;
    localparam logic [3:0] TYPE_INT16 = 4'd2;
    localparam logic [3:0] TYPE_INT32 = 4'd3;
    localparam logic [3:0] TYPE_FLOAT = 4'd4;

    // One result of the parser.
    typedef struct packed {
        logic        valid;
        logic [63:0] name_low;
        logic [63:0] name_high;
        logic [4:0]  name_length;
        logic [3:0]  param_type;
        logic [31:0] value_bits;
        logic        has_default;
        logic [31:0] default_bits;
        logic [15:0] record_index;
        status_t     status;
        logic        is_record;
        logic        final_res;
    } result_t;

    // Write request into the name store.
    typedef struct packed {
        logic                  en;
        logic [NAME_IDX_W-1:0] idx;
        logic [7:0]            data;
    } name_wr_t;

    // Number of value bytes for a type, zero for an unknown type.
    function automatic logic [2:0] value_size(input logic [3:0] t);
        logic [2:0] sz;
        case (t)
            TYPE_INT8:  sz = 3'd1;
            TYPE_INT16: sz = 3'd2;
            TYPE_INT32: sz = 3'd4;
            TYPE_FLOAT: sz = 3'd4;
            default:    sz = 3'd0;
        endcase
        return sz;
    endfunction

    // Sign-extends the narrow integer types to 32 bits.
    function automatic logic [31:0] widen(input logic [31:0] v, input logic [3:0] t);
        logic [31:0] r;
        case (t)
            TYPE_INT8:  r = {{24{v[7]}}, v[7:0]};
            TYPE_INT16: r = {{16{v[15]}}, v[15:0]};
            default:    r = v;
        endcase
        return r;
    endfunction

endpackage

FILE: src/ppf_name_store.sv
// ============================================================================
// ppf_name_store
// Holds the current front-coded name and presents it as two 64-bit words,
// zero beyond the stored length.
// ============================================================================
module ppf_name_store #(
    parameter int NAME_MAX = ppf_pkg::NAME_MAX_DEF
) (
    input  logic              clk,
    input  ppf_pkg::name_wr_t wr,
    input  logic [4:0]        name_length,
    output logic [63:0]       name_low,
    output logic [63:0]       name_high
);

    localparam int IDX_W = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;

    logic [7:0]   store_reg [NAME_MAX];
    logic [127:0] name_bits;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            store_reg[wr.idx[IDX_W-1:0]] <= wr.data;
        end
    end

    // Each byte lane reads its own fixed entry.
    for (genvar gi = 0; gi < 16; gi++)
    begin : g_lane
        if (gi < NAME_MAX)
        begin : g_used
            assign name_bits[gi*8 +: 8] = (5'(gi) < name_length) ? store_reg[gi] : 8'h00;
        end
        else
        begin : g_unused
            assign name_bits[gi*8 +: 8] = 8'h00;
        end
    end

    assign name_low  = name_bits[63:0];
    assign name_high = name_bits[127:64];

endmodule

FILE: src/ppf_parser.sv
// ============================================================================
// ppf_parser
// Parser state and the per-byte decode: header check, padding skip, record
// fields, value assembly and result formation.
// ============================================================================
module ppf_parser #(
    parameter int NAME_MAX = ppf_pkg::NAME_MAX_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic [63:0]       name_low,
    input  logic [63:0]       name_high,
    output logic [4:0]        stored_len,
    output ppf_pkg::name_wr_t name_wr,
    output ppf_pkg::result_t  result
);

    ppf_pkg::phase_t phase_reg, phase_next;
    logic [4:0]  pos_reg, pos_next;
    logic [15:0] magic_reg, magic_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] done_reg, done_next;
    logic [4:0]  stored_reg, stored_next;
    logic [4:0]  pending_reg, pending_next;
    logic [7:0]  flags_reg, flags_next;
    logic [31:0] value_reg, value_next;
    logic [31:0] default_reg, default_next;

    logic             rep;
    ppf_pkg::status_t rep_status;
    logic [3:0]       ptype;
    logic [2:0]       sz;
    logic [4:0]       pos_inc;
    logic [4:0]       new_len;
    logic [4:0]       pfx_sum;
    logic [31:0]      byte_shifted;

    assign stored_len = stored_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= ppf_pkg::PH_HEADER;
            pos_reg     <= '0;
            magic_reg   <= '0;
            count_reg   <= '0;
            total_reg   <= '0;
            done_reg    <= '0;
            stored_reg  <= '0;
            pending_reg <= '0;
            flags_reg   <= '0;
            value_reg   <= '0;
            default_reg <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            magic_reg   <= magic_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            done_reg    <= done_next;
            stored_reg  <= stored_next;
            pending_reg <= pending_next;
            flags_reg   <= flags_next;
            value_reg   <= value_next;
            default_reg <= default_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        magic_next   = magic_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        done_next    = done_reg;
        stored_next  = stored_reg;
        pending_next = pending_reg;
        flags_next   = flags_reg;
        value_next   = value_reg;
        default_next = default_reg;
        result       = '0;
        name_wr      = '0;
        rep          = 1'b0;
        rep_status   = ppf_pkg::ST_OK;
        ptype        = flags_reg[3:0];
        sz           = ppf_pkg::value_size(flags_reg[3:0]);
        pos_inc      = pos_reg + 5'd1;
        new_len      = {1'b0, data_byte[7:4]} + 5'd1;
        pfx_sum      = {1'b0, data_byte[3:0]} + new_len;
        byte_shifted = 32'(data_byte) << {pos_reg[1:0], 3'b000};

        case (phase_reg)
            ppf_pkg::PH_HEADER:
            begin
                case (pos_reg)
                    5'd0:    magic_next = {8'h00, data_byte};
                    5'd1:    magic_next = {data_byte, magic_reg[7:0]};
                    5'd2:    count_next = {8'h00, data_byte};
                    5'd3:    count_next = {data_byte, count_reg[7:0]};
                    5'd4:    total_next = {8'h00, data_byte};
                    default: total_next = {data_byte, total_reg[7:0]};
                endcase
                done_next   = '0;
                stored_next = '0;
                if (pos_reg < ppf_pkg::HDR_LAST_POS)
                begin
                    pos_next = pos_inc;
                    if (last_byte)
                    begin
                        rep        = 1'b1;
                        rep_status = ppf_pkg::ST_TOO_SMALL;
                    end
                end
                else
                begin
                    pos_next = '0;
                    if (magic_next != ppf_pkg::MAGIC_A && magic_next != ppf_pkg::MAGIC_B)
                    begin
                        rep        = 1'b1;
                        rep_status = ppf_pkg::ST_BAD_MAGIC;
                    end
                    else if (count_next != total_next)
                    begin
                        rep        = 1'b1;
                        rep_status = ppf_pkg::ST_PARTIAL;
                    end
                    else if (count_next == 16'd0)
                    begin
                        rep        = 1'b1;
                        rep_status = ppf_pkg::ST_OK;
                    end
                    else
                    begin
                        phase_next = ppf_pkg::PH_PAD;
                        if (last_byte)
                        begin
                            rep        = 1'b1;
                            rep_status = ppf_pkg::ST_END_EARLY;
                        end
                    end
                end
            end

            ppf_pkg::PH_PAD:
            begin
                if (data_byte != 8'h00)
                begin
                    flags_next = data_byte;
                    phase_next = ppf_pkg::PH_NAMEBYTE;
                end
                if (last_byte)
                begin
                    rep        = 1'b1;
                    rep_status = ppf_pkg::ST_END_EARLY;
                end
            end

            ppf_pkg::PH_NAMEBYTE:
            begin
                if ({1'b0, data_byte[3:0]} > stored_reg || pfx_sum > 5'(NAME_MAX))
                begin
                    rep        = 1'b1;
                    rep_status = ppf_pkg::ST_BAD_PREFIX;
                end
                else
                begin
                    pending_next = pfx_sum;
                    pos_next     = {1'b0, data_byte[3:0]};
                    phase_next   = ppf_pkg::PH_NAME;
                    if (last_byte)
                    begin
                        rep        = 1'b1;
                        rep_status = ppf_pkg::ST_TRUNC_NAME;
                    end
                end
            end

            ppf_pkg::PH_NAME:
            begin
                if (pos_reg < 5'(NAME_MAX))
                begin
                    name_wr.en   = 1'b1;
                    name_wr.idx  = pos_reg[ppf_pkg::NAME_IDX_W-1:0];
                    name_wr.data = data_byte;
                end
                if (pos_inc >= pending_reg)
                begin
                    stored_next  = pending_reg;
                    pos_next     = '0;
                    value_next   = '0;
                    default_next = '0;
                    if (sz == 3'd0)
                    begin
                        rep        = 1'b1;
                        rep_status = ppf_pkg::ST_BAD_VALUE;
                    end
                    else
                    begin
                        phase_next = ppf_pkg::PH_VALUE;
                        if (last_byte)
                        begin
                            rep        = 1'b1;
                            rep_status = ppf_pkg::ST_BAD_VALUE;
                        end
                    end
                end
                else
                begin
                    pos_next = pos_inc;
                    if (last_byte)
                    begin
                        rep        = 1'b1;
                        rep_status = ppf_pkg::ST_TRUNC_NAME;
                    end
                end
            end

            ppf_pkg::PH_VALUE,
            ppf_pkg::PH_DEFAULT:
            begin
                if (pos_reg < 5'd4)
                begin
                    if (phase_reg == ppf_pkg::PH_VALUE)
                    begin
                        value_next = value_reg | byte_shifted;
                    end
                    else
                    begin
                        default_next = default_reg | byte_shifted;
                    end
                end
                if (pos_inc >= {2'b00, sz})
                begin
                    pos_next = '0;
                    if (phase_reg == ppf_pkg::PH_VALUE && flags_reg[4])
                    begin
                        phase_next = ppf_pkg::PH_DEFAULT;
                        if (last_byte)
                        begin
                            rep        = 1'b1;
                            rep_status = ppf_pkg::ST_TRUNC_DFLT;
                        end
                    end
                    else
                    begin
                        // Record complete.
                        result.valid        = 1'b1;
                        result.name_low     = name_low;
                        result.name_high    = name_high;
                        result.name_length  = stored_reg;
                        result.param_type   = ptype;
                        result.value_bits   = ppf_pkg::widen(value_next, ptype);
                        result.has_default  = flags_reg[4];
                        result.default_bits = flags_reg[4] ?
                                              ppf_pkg::widen(default_next, ptype) : 32'd0;
                        result.record_index = done_reg;
                        result.status       = ppf_pkg::ST_OK;
                        result.is_record    = 1'b1;
                        done_next           = done_reg + 16'd1;
                        if (done_next == count_reg)
                        begin
                            result.final_res = 1'b1;
                            phase_next = last_byte ? ppf_pkg::PH_HEADER : ppf_pkg::PH_IGNORE;
                        end
                        else if (last_byte)
                        begin
                            result.status    = ppf_pkg::ST_END_EARLY;
                            result.final_res = 1'b1;
                            phase_next       = ppf_pkg::PH_HEADER;
                        end
                        else
                        begin
                            phase_next = ppf_pkg::PH_PAD;
                        end
                    end
                end
                else
                begin
                    pos_next = pos_inc;
                    if (last_byte)
                    begin
                        rep        = 1'b1;
                        rep_status = (phase_reg == ppf_pkg::PH_VALUE) ?
                                     ppf_pkg::ST_BAD_VALUE : ppf_pkg::ST_TRUNC_DFLT;
                    end
                end
            end

            default:
            begin
                // Skipping the rest of a finished file.
                if (last_byte)
                begin
                    phase_next = ppf_pkg::PH_HEADER;
                    pos_next   = '0;
                end
            end
        endcase

        // A report ends the file: wait for its final byte unless this is it.
        if (rep)
        begin
            result              = '0;
            result.valid        = 1'b1;
            result.record_index = done_next;
            result.status       = rep_status;
            result.final_res    = 1'b1;
            phase_next          = last_byte ? ppf_pkg::PH_HEADER : ppf_pkg::PH_IGNORE;
            pos_next            = '0;
        end
    end

endmodule

FILE: src/packed_param_file_parser_top.sv
// ============================================================================
// packed_param_file_parser_top
// Byte-stream parser for packed parameter files: header check, record decode
// with front-coded names, one result per record or one done/error report.
// ============================================================================
// Flow: a request is latched into the input register and decoded into the
// result register once that register is free to take the result.
// Throughput: one byte per cycle; each byte is one pass of short logic on the
// registered parser state. A stalled result holds the byte behind it.
// Reset: rst_n returns the parser to the header phase and empties both
// registers; the name store is not cleared, as each file starts with no name.
// ============================================================================
module packed_param_file_parser_top #(
    parameter int NAME_MAX = ppf_pkg::NAME_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    // Input channel: one file byte per request.
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,

    // Output channel: one record or report per request.
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] name_low,
    output logic [63:0] name_high,
    output logic [4:0]  name_length,
    output logic [3:0]  param_type,
    output logic [31:0] value_bits,
    output logic        has_default,
    output logic [31:0] default_bits,
    output logic [15:0] record_index,
    output logic [3:0]  status,
    output logic        is_record,
    output logic        final_res
);

    // Input register stage.
    logic       s1_valid_reg;
    logic [7:0] s1_data_reg;
    logic       s1_last_reg;

    // Result register stage.
    logic              out_valid_reg;
    ppf_pkg::result_t  res_reg;

    // Internal wiring.
    logic              out_free;
    logic              s1_step;
    logic              in_fire;
    logic [4:0]        stored_len;
    logic [63:0]       store_low;
    logic [63:0]       store_high;
    ppf_pkg::name_wr_t name_wr;
    ppf_pkg::result_t  res_comb;

    // The byte in the input register is decoded once the result register can
    // take whatever it produces: either the register is empty or its request
    // is being taken in this cycle. A new byte may enter the input register
    // whenever the current one moves on, so a stalled result also stops the
    // next byte from being latched.
    assign out_free = !out_valid_reg || out_ready;
    assign s1_step  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_data_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

    ppf_parser #(
        .NAME_MAX (NAME_MAX)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s1_step),
        .data_byte  (s1_data_reg),
        .last_byte  (s1_last_reg),
        .name_low   (store_low),
        .name_high  (store_high),
        .stored_len (stored_len),
        .name_wr    (name_wr),
        .result     (res_comb)
    );

    // The write strobe only takes effect when the parser actually steps.
    ppf_pkg::name_wr_t name_wr_gated;
    always_comb
    begin
        name_wr_gated    = name_wr;
        name_wr_gated.en = name_wr.en && s1_step;
    end

    ppf_name_store #(
        .NAME_MAX (NAME_MAX)
    ) u_name_store (
        .clk         (clk),
        .wr          (name_wr_gated),
        .name_length (stored_len),
        .name_low    (store_low),
        .name_high   (store_high)
    );

    // Result register: loads when a decoded byte yields a result, drains when
    // the downstream side takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_step && res_comb.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_step && res_comb.valid)
        begin
            res_reg <= res_comb;
        end
    end

    assign out_valid    = out_valid_reg;
    assign name_low     = res_reg.name_low;
    assign name_high    = res_reg.name_high;
    assign name_length  = res_reg.name_length;
    assign param_type   = res_reg.param_type;
    assign value_bits   = res_reg.value_bits;
    assign has_default  = res_reg.has_default;
    assign default_bits = res_reg.default_bits;
    assign record_index = res_reg.record_index;
    assign status       = res_reg.status;
    assign is_record    = res_reg.is_record;
    assign final_res    = res_reg.final_res;

endmodule
